FILE: sv/pcx_rle_pkg.sv
// Shared types and constants of the PCX run-length line decoder.
// Used by the front classifier, the command queue, the executor and the top level.
package pcx_rle_pkg;

  localparam int unsigned QueueDepth     = 4;
  localparam logic [15:0] LineBytesReset = 16'd320;
  localparam logic [7:0]  RunMark        = 8'hC0;
  localparam logic [7:0]  CountMask      = 8'h3F;

  typedef enum logic [1:0] {
    CMD_LIT = 2'd0,
    CMD_RUN = 2'd1,
    CMD_EOF = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    STATUS_PIXEL     = 2'd0,
    STATUS_CLEAN_END = 2'd1,
    STATUS_UNEXP_END = 2'd2,
    STATUS_OVERRUN   = 2'd3
  } status_e;

  // One decoded command handed from the front to the executor.
  typedef struct packed {
    cmd_kind_e   kind;
    logic        eof_err;  // end of file arrived while a run value was awaited
    logic [7:0]  data;
    logic [5:0]  count;
  } cmd_t;

endpackage

FILE: sv/pcx_rle_front.sv
// Front stage of the PCX decoder: accepts encoded bytes and turns them into commands.
// Depends on pcx_rle_pkg for the command type and the run-code constants.
module pcx_rle_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_file_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output pcx_rle_pkg::cmd_t   cmd_o
);

  logic       awaiting_q, awaiting_d;
  logic [5:0] pending_q, pending_d;
  logic       is_run_code;
  logic       accept;

  assign is_run_code = (data_byte_i & pcx_rle_pkg::RunMark) == pcx_rle_pkg::RunMark;
  assign in_ready_o  = !queue_full_i;
  assign accept      = in_valid_i && in_ready_o;

  // A run code only loads the pending count; every other item becomes a command.
  assign push_o = accept && (end_of_file_i || awaiting_q || !is_run_code);

  always_comb begin
    cmd_o.data    = data_byte_i;
    cmd_o.count   = pending_q;
    cmd_o.eof_err = awaiting_q;
    if (end_of_file_i) begin
      cmd_o.kind = pcx_rle_pkg::CMD_EOF;
    end else if (awaiting_q) begin
      cmd_o.kind = pcx_rle_pkg::CMD_RUN;
    end else begin
      cmd_o.kind = pcx_rle_pkg::CMD_LIT;
    end
  end

  always_comb begin
    awaiting_d = awaiting_q;
    pending_d  = pending_q;
    if (accept && !end_of_file_i) begin
      if (awaiting_q) begin
        awaiting_d = 1'b0;
        pending_d  = 6'd0;
      end else if (is_run_code) begin
        awaiting_d = 1'b1;
        pending_d  = 6'(data_byte_i & pcx_rle_pkg::CountMask);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      pending_q  <= 6'd0;
    end else begin
      awaiting_q <= awaiting_d;
      pending_q  <= pending_d;
    end
  end

endmodule

FILE: sv/pcx_rle_fifo.sv
// Short command queue between the front and the executor of the PCX decoder.
// Depends on pcx_rle_pkg for the command type.
module pcx_rle_fifo #(
  parameter int unsigned DEPTH = pcx_rle_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pcx_rle_pkg::cmd_t   data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output pcx_rle_pkg::cmd_t   data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  pcx_rle_pkg::cmd_t  entries_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = count_q == FullCnt;
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/pcx_rle_back.sv
// Executor of the PCX decoder: runs commands, tracks the line column, drives the output register.
// Depends on pcx_rle_pkg for the command type and the status codes.
module pcx_rle_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         line_bytes_i,
  input  logic                queue_empty_i,
  input  pcx_rle_pkg::cmd_t   cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          pixel_o,
  output logic [15:0]         column_o,
  output logic                line_done_o,
  output logic                run_last_o,
  output pcx_rle_pkg::status_e status_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_e;

  back_state_e          state_q, state_d;
  logic                 halted_q, halted_d;
  logic [15:0]          pos_q, pos_d;
  logic [7:0]           byte_q, byte_d;
  logic [5:0]           remain_q, remain_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [7:0]           pixel_d;
  logic [15:0]          column_d;
  logic                 line_done_d, run_last_d;
  pcx_rle_pkg::status_e status_d;
  logic                 out_free;
  logic [16:0]          len_eff, pos_inc, run_end;
  logic                 px_done;

  assign out_free = !out_valid_q || out_ready_i;
  assign len_eff  = (line_bytes_i == 16'd0) ? 17'd1 : {1'b0, line_bytes_i};
  assign pos_inc  = {1'b0, pos_q} + 17'd1;
  assign run_end  = {1'b0, pos_q} + {11'd0, cmd_i.count};
  assign px_done  = pos_inc >= len_eff;
  assign pop_o    = (state_q == ST_IDLE) && !queue_empty_i && out_free;

  always_comb begin
    state_d     = state_q;
    halted_d    = halted_q;
    pos_d       = pos_q;
    byte_d      = byte_q;
    remain_d    = remain_q;
    out_load    = 1'b0;
    pixel_d     = 8'd0;
    column_d    = pos_q;
    line_done_d = 1'b0;
    run_last_d  = 1'b1;
    status_d    = pcx_rle_pkg::STATUS_PIXEL;

    case (state_q)
      ST_IDLE: begin
        if (pop_o && !halted_q) begin
          case (cmd_i.kind)
            pcx_rle_pkg::CMD_LIT: begin
              out_load    = 1'b1;
              pixel_d     = cmd_i.data;
              line_done_d = px_done;
              pos_d       = px_done ? 16'd0 : pos_inc[15:0];
            end
            pcx_rle_pkg::CMD_EOF: begin
              out_load = 1'b1;
              if (cmd_i.eof_err || pos_q != 16'd0) begin
                status_d = pcx_rle_pkg::STATUS_UNEXP_END;
                halted_d = 1'b1;
              end else begin
                status_d = pcx_rle_pkg::STATUS_CLEAN_END;
              end
            end
            pcx_rle_pkg::CMD_RUN: begin
              if (run_end > len_eff) begin
                out_load = 1'b1;
                status_d = pcx_rle_pkg::STATUS_OVERRUN;
                halted_d = 1'b1;
              end else if (cmd_i.count != 6'd0) begin
                // The first pixel of the run goes out right away.
                out_load    = 1'b1;
                pixel_d     = cmd_i.data;
                line_done_d = px_done;
                run_last_d  = cmd_i.count == 6'd1;
                pos_d       = px_done ? 16'd0 : pos_inc[15:0];
                byte_d      = cmd_i.data;
                remain_d    = cmd_i.count - 6'd1;
                if (cmd_i.count != 6'd1) begin
                  state_d = ST_RUN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_load    = 1'b1;
          pixel_d     = byte_q;
          line_done_d = px_done;
          run_last_d  = remain_q == 6'd1;
          pos_d       = px_done ? 16'd0 : pos_inc[15:0];
          remain_d    = remain_q - 6'd1;
          if (remain_q == 6'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      halted_q    <= 1'b0;
      pos_q       <= 16'd0;
      remain_q    <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      halted_q    <= halted_d;
      pos_q       <= pos_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (out_load) begin
      pixel_o     <= pixel_d;
      column_o    <= column_d;
      line_done_o <= line_done_d;
      run_last_o  <= run_last_d;
      status_o    <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/pcx_rle_line_decoder_top.sv
// Top level of the PCX run-length line decoder.
// Instantiates pcx_rle_front, pcx_rle_fifo and pcx_rle_back; uses pcx_rle_pkg.
//
// Usage: encoded PCX bytes arrive one per transfer on the s_axis channel, with
// tuser marking the end of file. Decoded pixels leave on the m_axis channel
// together with their column, a line-complete flag and a status code; tlast is
// set on the final result that one input byte causes. The line length is written
// through the cfg channel, which is always ready, and the user must write it only
// while the block is idle; the block itself does not enforce this. A front stage
// classifies bytes into literal, run and end-of-file commands and keeps the pending
// run count; a queue of QUEUE_DEPTH commands feeds the executor. A result passes
// through the command queue and the output register. The executor takes a literal
// or an end of file with one pop and gives a run one pixel per cycle while the
// receiver takes them; a run code byte alone uses no executor time.
// When the receiver stalls, the output register holds its result, the executor
// waits, and input is still taken until the queue fills.
// After an overrun or an unexpected end the block keeps taking input but gives no
// further results until reset. Reset clears the queue, the column and the error
// state, and restores the line length to 320.
module pcx_rle_line_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = pcx_rle_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: line length in decoded bytes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] end_of_file
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] pixel, [23:8] column, [24] line_done, rest 0
  output logic        m_axis_tlast,   // run_last
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic                 cfg_write;
  logic [15:0]          line_len_q;
  logic                 fifo_push, fifo_pop, fifo_full, fifo_empty;
  pcx_rle_pkg::cmd_t    cmd_in, cmd_out;
  logic [7:0]           pixel;
  logic [15:0]          column;
  logic                 line_done;
  pcx_rle_pkg::status_e status;

  // The configuration channel never stalls.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= pcx_rle_pkg::LineBytesReset;
    end else if (cfg_write) begin
      line_len_q <= cfg_data_i;
    end
  end

  pcx_rle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .data_byte_i   (s_axis_tdata),
    .end_of_file_i (s_axis_tuser),
    .queue_full_i  (fifo_full),
    .push_o        (fifo_push),
    .cmd_o         (cmd_in)
  );

  pcx_rle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (cmd_in),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (cmd_out)
  );

  pcx_rle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_bytes_i  (line_len_q),
    .queue_empty_i (fifo_empty),
    .cmd_i         (cmd_out),
    .pop_o         (fifo_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_o       (pixel),
    .column_o      (column),
    .line_done_o   (line_done),
    .run_last_o    (m_axis_tlast),
    .status_o      (status)
  );

  assign m_axis_tdata = {7'd0, line_done, column, pixel};
  assign m_axis_tuser = status;

`ifndef SYNTHESIS
  // A status result is always the only result of its input byte.
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status != pcx_rle_pkg::STATUS_PIXEL) |-> m_axis_tlast)
    else $error("status result without tlast");

  // A status result carries no pixel and never completes a line.
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status != pcx_rle_pkg::STATUS_PIXEL) |-> (pixel == 8'd0 && !line_done))
    else $error("status result carries pixel data");

  // The queue cannot report full and empty together.
  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_full && fifo_empty))
    else $error("command queue full and empty at once");

  // A command popped from the queue was present before the pop.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("command popped from an empty queue");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the PCX run-length line decoder: directed and random
// byte streams, a pixel predictor kept in the testbench, and a scoreboard on m_axis.
// Depends on pcx_rle_pkg and pcx_rle_line_decoder_top.
module tb_top;

  // Spare cycles after the last owed result let a run code that causes no result
  // settle before the line length is rewritten.
  localparam int SettleCycles = 8;
  localparam int ResetCycles  = 12;

  // One decoded result as it should appear on the output stream.
  typedef struct packed {
    logic [7:0]           pixel;
    logic [15:0]          column;
    logic                 line_done;
    logic                 run_last;
    pcx_rle_pkg::status_e status;
  } pixel_rec_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;    // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0;  // [0] end_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [7:0] pixel, [23:8] column, [24] line_done
  logic        m_axis_tlast;          // run_last
  logic [1:0]  m_axis_tuser;          // [1:0] status

  // Decoder state as the testbench predicts it. It is updated at the clock edge at
  // which an input transfer takes place, so it always describes the next byte.
  logic [15:0] line_len   = pcx_rle_pkg::LineBytesReset;
  logic        wait_value = 1'b0;
  logic [5:0]  run_count  = '0;
  logic [15:0] column     = '0;
  logic        halted     = 1'b0;

  // Results still owed by the DUT, oldest first.
  pixel_rec_t expected_px[$];

  // Percentages of cycles in which the sender and the receiver hold back.
  int send_idle_pct = 6;
  int recv_idle_pct = 80;
  // Cycles for which the receiver keeps tready low regardless of its idle rate.
  int hold_left     = 0;
  int mismatches    = 0;

  pcx_rle_line_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pixel predictor
  // ---------------------------------------------------------------------------

  // A line length of zero behaves as a length of one.
  function automatic logic [16:0] active_len();
    return (line_len == 16'd0) ? 17'd1 : {1'b0, line_len};
  endfunction

  // Pixels left before the line end; negative after the length was cut below the column.
  function automatic int line_room();
    return int'(active_len()) - int'(column);
  endfunction

  task automatic push_pixel(input logic [7:0] b, input logic last);
    pixel_rec_t r;
    r.pixel     = b;
    r.column    = column;
    r.line_done = ({1'b0, column} + 17'd1 >= active_len());
    r.run_last  = last;
    r.status    = pcx_rle_pkg::STATUS_PIXEL;
    expected_px.push_back(r);
    column = r.line_done ? 16'd0 : column + 16'd1;
  endtask

  task automatic push_status(input pcx_rle_pkg::status_e st);
    pixel_rec_t r;
    r.pixel     = 8'd0;
    r.column    = column;
    r.line_done = 1'b0;
    r.run_last  = 1'b1;
    r.status    = st;
    expected_px.push_back(r);
  endtask

  // Works out the results of one accepted input byte and advances the state.
  task automatic decode_byte(input logic [7:0] b, input logic eof);
    logic [5:0] n;
    if (halted) return;
    if (eof) begin
      // An end of file after a run code or inside a line is an error that halts
      // the decoder; at a line boundary it is a clean end and decoding goes on.
      if (wait_value || column != 16'd0) begin
        push_status(pcx_rle_pkg::STATUS_UNEXP_END);
        halted = 1'b1;
      end else begin
        push_status(pcx_rle_pkg::STATUS_CLEAN_END);
      end
    end else if (wait_value) begin
      n          = run_count;
      wait_value = 1'b0;
      run_count  = '0;
      if ({1'b0, column} + n > active_len()) begin
        push_status(pcx_rle_pkg::STATUS_OVERRUN);
        halted = 1'b1;
      end else begin
        // A zero count consumes the value byte and gives nothing.
        for (int k = 0; k < n; k++) push_pixel(b, k == n - 1);
      end
    end else if ((b & pcx_rle_pkg::RunMark) == pcx_rle_pkg::RunMark) begin
      wait_value = 1'b1;
      run_count  = 6'(b & pcx_rle_pkg::CountMask);
    end else begin
      push_pixel(b, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t ns: %s", $realtime, msg);
  endfunction

  task automatic check_result();
    pixel_rec_t want;
    if (expected_px.size() == 0) begin
      note_mismatch($sformatf("result with nothing expected: tdata %h tlast %b tuser %0d",
                              m_axis_tdata, m_axis_tlast, m_axis_tuser));
      return;
    end
    want = expected_px.pop_front();
    if (m_axis_tdata[7:0] != want.pixel)
      note_mismatch($sformatf("pixel at column %0d: expected %h, got %h",
                              want.column, want.pixel, m_axis_tdata[7:0]));
    if (m_axis_tdata[23:8] != want.column)
      note_mismatch($sformatf("column: expected %0d, got %0d",
                              want.column, m_axis_tdata[23:8]));
    if (m_axis_tdata[24] != want.line_done)
      note_mismatch($sformatf("line_done at column %0d: expected %b, got %b",
                              want.column, want.line_done, m_axis_tdata[24]));
    if (m_axis_tdata[31:25] != 7'd0)
      note_mismatch($sformatf("tdata padding: expected 0, got %h", m_axis_tdata[31:25]));
    if (m_axis_tlast != want.run_last)
      note_mismatch($sformatf("run_last at column %0d: expected %b, got %b",
                              want.column, want.run_last, m_axis_tlast));
    if (m_axis_tuser != want.status)
      note_mismatch($sformatf("status at column %0d: expected %s, got %0d",
                              want.column, want.status.name(), m_axis_tuser));
  endtask

  // The receiver checks every output transfer and then decides tready for the next
  // cycle. A hold request from a test keeps tready low for that many cycles.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one byte and returns at the edge of its transfer. tvalid stays high so
  // that the next byte may follow at once; an idle gap lowers it first.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, eof);
  endtask

  task automatic send_run(input logic [5:0] count, input logic [7:0] value);
    send_byte(pcx_rle_pkg::RunMark | 8'(count), 1'b0);
    send_byte(value, 1'b0);
  endtask

  task automatic send_literal();
    send_byte(8'($urandom_range(8'hBF)), 1'b0);
  endtask

  // The sender stops and waits until every owed result has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The line length is only rewritten while the decoder has nothing in flight.
  task automatic write_line_len(input logic [15:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    line_len = v;
  endtask

  // Literals always fit, so they are used to bring the column back to zero.
  task automatic finish_line();
    while (column != 16'd0) send_literal();
  endtask

  function automatic logic [15:0] pick_line_len();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd1;
    if (r == 2) return 16'd2;
    if (r <= 6) return 16'($urandom_range(64, 3));
    return 16'($urandom_range(400, 65));
  endfunction

  // Mostly well-formed content: literals and runs that fit the line, with zero-count
  // runs and clean ends at line boundaries mixed in. Runs never cause an error here.
  task automatic random_stream(input int n);
    int sent;
    int pick;
    int room;
    int top;
    logic [5:0] cnt;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      room = line_room();
      if (pick < 45 || room < 0) begin
        send_literal();
        sent++;
      end else if (pick < 85) begin
        top = (room < 63) ? room : 63;
        if (top == 0)     cnt = 6'd0;
        else if (pick < 52) cnt = 6'(top);
        else              cnt = 6'($urandom_range(top, 1));
        send_run(cnt, 8'($urandom_range(255)));
        sent += 2;
      end else if (pick < 92) begin
        send_run(6'd0, 8'($urandom_range(255)));
        sent += 2;
      end else if (column == 16'd0) begin
        // The data byte beside an end of file is random, since it is ignored.
        send_byte(8'($urandom_range(255)), 1'b1);
        sent++;
      end else begin
        send_literal();
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Literal extremes and full-count runs fill exactly one line of the reset length.
  task automatic test_reset_line_length();
    send_byte(8'h00, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h40, 1'b0);
    send_run(6'd63, 8'hFF);
    send_run(6'd63, 8'hC0);
    send_run(6'd63, 8'h3E);
    send_run(6'd63, 8'h81);
    send_run(6'd63, 8'h55);
    send_run(6'd2, 8'hAA);
  endtask

  // A zero-count run gives nothing; a one-pixel run ends on its only pixel.
  task automatic test_short_runs();
    send_run(6'd0, 8'h12);
    send_run(6'd1, 8'h00);
  endtask

  // Lengths of one and zero end every pixel's line, and clean ends fall between them.
  task automatic test_clean_end();
    write_line_len(16'd1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC7, 1'b1);
    send_run(6'd1, 8'hE0);
    write_line_len(16'd0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // A shorter length written mid-line takes effect on the very next pixel.
  task automatic test_length_change();
    write_line_len(16'd10);
    send_literal();
    send_literal();
    send_literal();
    write_line_len(16'd2);
    send_byte(8'h7F, 1'b0);
    send_run(6'd2, 8'h5A);
  endtask

  // The receiver holds off long enough for the queue to fill and the input to stall.
  task automatic test_backpressure();
    hold_left = 300;
    repeat (24) send_literal();
    if (line_room() > 0) send_run(6'(line_room() < 20 ? line_room() : 20), 8'h99);
    drain();
  endtask

  task automatic test_random_phase(input int s_pct, input int r_pct, input int n);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (4) begin
      write_line_len(pick_line_len());
      random_stream(n / 4);
    end
  endtask

  // The widest line: full runs stay inside it and never complete it.
  task automatic test_wide_line();
    finish_line();
    write_line_len(16'hFFFF);
    repeat (4) send_run(6'd63, 8'($urandom_range(255)));
    send_literal();
  endtask

  // Only one error can be seen per run, since the decoder stays halted until reset;
  // the seed chooses which one. Bytes sent afterwards must give no result.
  task automatic test_halt();
    int mode;
    mode = $urandom_range(2);
    write_line_len(16'd40);
    finish_line();
    case (mode)
      0: begin
        // Run overrun, one pixel beyond the line end.
        send_literal();
        send_run(6'd40, 8'h66);
      end
      1: begin
        // End of file inside a line.
        send_literal();
        send_byte(8'hFF, 1'b1);
      end
      default: begin
        // End of file right after a run code.
        send_byte(pcx_rle_pkg::RunMark | 8'd5, 1'b0);
        send_byte(8'h00, 1'b1);
      end
    endcase
    repeat (8) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender nearly always ready, receiver mostly stalled.
    test_reset_line_length();
    test_short_runs();
    test_clean_end();
    test_length_change();
    test_random_phase(6, 80, 136);
    // Roles swapped, then no idling at all.
    test_random_phase(80, 6, 136);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_phase(0, 0, 136);
    test_wide_line();
    test_halt();
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: a run that hangs on a missing result ends here.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
